/* hdl/cc20_pkg.sv */
// cc20_pkg: shared types, constants and state encodings for the ChaCha20 stream XOR block.
// Used by cc20_block and chacha20_stream_xor. No dependencies.
package cc20_pkg;

	localparam int unsigned CC20_DOUBLE_ROUNDS = 10;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	typedef logic [15:0][31:0] words_t;
	typedef logic [7:0][31:0]  key_words_t;
	typedef logic [2:0][31:0]  nonce_words_t;

	typedef struct packed {
		key_words_t   key;
		nonce_words_t nonce;
	} cipher_cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} msg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} res_t;

	typedef enum logic [2:0] {
		CFG_KEY_0         = 3'd0,
		CFG_KEY_1         = 3'd1,
		CFG_KEY_2         = 3'd2,
		CFG_KEY_3         = 3'd3,
		CFG_NONCE_LOW     = 3'd4,
		CFG_NONCE_HIGH    = 3'd5,
		CFG_START_COUNTER = 3'd6
	} cfg_idx_t;

	// block generator request / response
	typedef struct packed {
		logic        go;
		logic [31:0] counter;
	} blk_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} blk_rsp_t;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_GEN,
		TOP_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		BLK_IDLE,
		BLK_ROUND,
		BLK_FINAL
	} blk_state_t;

endpackage

/* hdl/cc20_qr.sv */
// cc20_qr: half of a ChaCha20 quarter round (two add-xor-rotate steps).
// Depends on nothing; the first half rotates by 16/12, the second by 8/7.
module cc20_qr (
	input  logic [31:0] a_in,
	input  logic [31:0] b_in,
	input  logic [31:0] c_in,
	input  logic [31:0] d_in,
	input  logic        second,
	output logic [31:0] a_out,
	output logic [31:0] b_out,
	output logic [31:0] c_out,
	output logic [31:0] d_out
);

	logic [31:0] a_sum;
	logic [31:0] d_mix;
	logic [31:0] c_sum;
	logic [31:0] b_mix;

	always_comb begin
		a_sum = a_in + b_in;
		d_mix = d_in ^ a_sum;
		d_out = second ? {d_mix[23:0], d_mix[31:24]} : {d_mix[15:0], d_mix[31:16]};
		c_sum = c_in + d_out;
		b_mix = b_in ^ c_sum;
		b_out = second ? {b_mix[24:0], b_mix[31:25]} : {b_mix[19:0], b_mix[31:20]};
		a_out = a_sum;
		c_out = c_sum;
	end

endmodule

/* hdl/cc20_block.sv */
// cc20_block: ChaCha20 block function on a 16-word state register, one half quarter round
// per cycle through a shared cc20_qr, then feed-forward add. Depends on cc20_pkg, cc20_qr.
module cc20_block #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::CC20_DOUBLE_ROUNDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cc20_pkg::cipher_cfg_t cfg,
	input  cc20_pkg::blk_req_t    req,
	output cc20_pkg::blk_rsp_t    rsp,
	output cc20_pkg::words_t      ks
);

	localparam int unsigned RND_W = $clog2(DOUBLE_ROUNDS);
	localparam logic [RND_W-1:0] LAST_RND = RND_W'(DOUBLE_ROUNDS - 1);

	cc20_pkg::blk_state_t st_q, st_d;
	cc20_pkg::words_t     words_q;
	cc20_pkg::words_t     stepped;
	cc20_pkg::words_t     final_words;
	cc20_pkg::words_t     init_fin;
	logic [31:0]          ctr_q;
	logic [RND_W-1:0]     rnd_q;
	logic [3:0]           step_q;
	logic                 done_q;
	logic [31:0]          qa, qb, qc, qd;

	function automatic cc20_pkg::words_t init_words(cc20_pkg::cipher_cfg_t c, logic [31:0] ctr);
		cc20_pkg::words_t w;
		w[0] = cc20_pkg::SIGMA_0;
		w[1] = cc20_pkg::SIGMA_1;
		w[2] = cc20_pkg::SIGMA_2;
		w[3] = cc20_pkg::SIGMA_3;
		for (int i = 0; i < 8; i++) begin
			w[4 + i] = c.key[i];
		end
		w[12] = ctr;
		w[13] = c.nonce[0];
		w[14] = c.nonce[1];
		w[15] = c.nonce[2];
		return w;
	endfunction

	// position j of the row takes word (j + amt) mod 4
	function automatic logic [3:0][31:0] rot_row(logic [3:0][31:0] row, logic [1:0] amt);
		logic [3:0][31:0] r;
		case (amt)
			2'd0: r = row;
			2'd1: r = {row[0], row[3], row[2], row[1]};
			2'd2: r = {row[1], row[0], row[3], row[2]};
			2'd3: r = {row[2], row[1], row[0], row[3]};
			default: r = row;
		endcase
		return r;
	endfunction

	// quarter round always works on column 0 (words 0, 4, 8, 12)
	cc20_qr u_qr (
		.a_in   (words_q[0]),
		.b_in   (words_q[4]),
		.c_in   (words_q[8]),
		.d_in   (words_q[12]),
		.second (step_q[0]),
		.a_out  (qa),
		.b_out  (qb),
		.c_out  (qc),
		.d_out  (qd)
	);

	// step_q: [3] diagonal round, [2:1] quarter round, [0] second half
	always_comb begin
		logic [1:0] amt;
		amt = 2'd1;
		stepped = words_q;
		stepped[0]  = qa;
		stepped[4]  = qb;
		stepped[8]  = qc;
		stepped[12] = qd;
		if (step_q[0]) begin
			for (int i = 0; i < 4; i++) begin
				// after the last quarter round of a half, rows also get
				// diagonalized (column round) or restored (diagonal round)
				if (step_q[2:1] != 2'd3) begin
					amt = 2'd1;
				end else if (step_q[3]) begin
					amt = 2'(1 - i);
				end else begin
					amt = 2'(1 + i);
				end
				stepped[4*i +: 4] = rot_row(stepped[4*i +: 4], amt);
			end
		end
	end

	always_comb begin
		init_fin = init_words(cfg, ctr_q);
		for (int j = 0; j < 16; j++) begin
			final_words[j] = words_q[j] + init_fin[j];
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			cc20_pkg::BLK_IDLE: begin
				if (req.go) st_d = cc20_pkg::BLK_ROUND;
			end
			cc20_pkg::BLK_ROUND: begin
				if (step_q == 4'hF && rnd_q == LAST_RND) st_d = cc20_pkg::BLK_FINAL;
			end
			cc20_pkg::BLK_FINAL: begin
				st_d = cc20_pkg::BLK_IDLE;
			end
			default: begin
				st_d = cc20_pkg::BLK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= cc20_pkg::BLK_IDLE;
			rnd_q  <= '0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == cc20_pkg::BLK_FINAL);
			if (st_q == cc20_pkg::BLK_IDLE && req.go) begin
				rnd_q  <= '0;
				step_q <= '0;
			end else if (st_q == cc20_pkg::BLK_ROUND) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'hF && rnd_q != LAST_RND) rnd_q <= rnd_q + RND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == cc20_pkg::BLK_IDLE && req.go) begin
			words_q <= init_words(cfg, req.counter);
			ctr_q   <= req.counter;
		end else if (st_q == cc20_pkg::BLK_ROUND) begin
			words_q <= stepped;
		end else if (st_q == cc20_pkg::BLK_FINAL) begin
			words_q <= final_words;
		end
	end

	assign rsp.busy = (st_q != cc20_pkg::BLK_IDLE);
	assign rsp.done = done_q;
	assign ks       = words_q;

`ifndef SYNTHESIS
	a_blk_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.go && st_q == cc20_pkg::BLK_IDLE) |-> ##(16*DOUBLE_ROUNDS+2) done_q)
		else $error("block done not seen at fixed latency");
	a_done_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(st_q) == cc20_pkg::BLK_FINAL && st_q == cc20_pkg::BLK_IDLE))
		else $error("done without final add");
	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rnd_q <= LAST_RND)
		else $error("round counter out of range");
`endif

endmodule

/* hdl/chacha20_stream_xor.sv */
// chacha20_stream_xor: ChaCha20 (RFC 8439) byte stream XOR; uses cc20_pkg and cc20_block.
// A byte inside a block gives its result the cycle after transfer; 1 byte/cycle unless
// res_stall holds the output. A byte at a block boundary waits for a new block from the
// shared round unit, which does one half quarter round per cycle; no new byte is taken
// meanwhile. Reset (arst_n, async low) clears config to 0, counter 0, offset 0, no message.
module chacha20_stream_xor #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::CC20_DOUBLE_ROUNDS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  cc20_pkg::msg_t msg_data,
	output logic           res_valid,
	input  logic           res_stall,
	output cc20_pkg::res_t res_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [63:0]    cfg_data
);

	// configuration registers
	cc20_pkg::cipher_cfg_t cfg_q;
	logic [31:0]           start_q;

	// stream position
	logic [31:0] ctr_q;
	logic [5:0]  off_q;
	logic        in_msg_q;

	cc20_pkg::top_state_t st_q, st_d;
	cc20_pkg::msg_t       pend_q;     // byte waiting on a fresh block
	cc20_pkg::res_t       res_q;
	logic                 res_valid_q;
	cc20_pkg::res_t       res_next;
	logic                 res_load;

	cc20_pkg::blk_req_t blk_req;
	cc20_pkg::blk_rsp_t blk_rsp;
	cc20_pkg::words_t   ks;

	logic        msg_xfer;
	logic        out_free;
	logic [5:0]  off_eff;
	logic [31:0] ctr_eff;
	logic [5:0]  off_next;
	logic [31:0] ks_word;
	logic [7:0]  ks_byte;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= '0;
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cc20_pkg::cfg_idx_t'(cfg_index))
				cc20_pkg::CFG_KEY_0: begin
					cfg_q.key[0] <= cfg_data[31:0];
					cfg_q.key[1] <= cfg_data[63:32];
				end
				cc20_pkg::CFG_KEY_1: begin
					cfg_q.key[2] <= cfg_data[31:0];
					cfg_q.key[3] <= cfg_data[63:32];
				end
				cc20_pkg::CFG_KEY_2: begin
					cfg_q.key[4] <= cfg_data[31:0];
					cfg_q.key[5] <= cfg_data[63:32];
				end
				cc20_pkg::CFG_KEY_3: begin
					cfg_q.key[6] <= cfg_data[31:0];
					cfg_q.key[7] <= cfg_data[63:32];
				end
				cc20_pkg::CFG_NONCE_LOW: begin
					cfg_q.nonce[0] <= cfg_data[31:0];
					cfg_q.nonce[1] <= cfg_data[63:32];
				end
				cc20_pkg::CFG_NONCE_HIGH: begin
					cfg_q.nonce[2] <= cfg_data[31:0];
				end
				cc20_pkg::CFG_START_COUNTER: begin
					start_q <= cfg_data[31:0];
				end
				default: begin
					// unmapped index: write dropped
				end
			endcase
		end
	end

	// A new message restarts at the start counter, offset 0.
	assign off_eff  = in_msg_q ? off_q : 6'd0;
	assign ctr_eff  = in_msg_q ? ctr_q : start_q;
	assign off_next = off_eff + 6'd1;

	// Keystream byte for the current offset, little-endian within each word.
	assign ks_word = ks[off_eff[5:2]];
	assign ks_byte = ks_word[{off_eff[1:0], 3'b000} +: 8];

	// The output register can take a result if empty or draining this cycle.
	assign out_free = !res_valid_q || !res_stall;
	assign msg_xfer = msg_valid && !msg_stall;

	cc20_block #(
		.DOUBLE_ROUNDS (DOUBLE_ROUNDS)
	) u_block (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (blk_req),
		.rsp    (blk_rsp),
		.ks     (ks)
	);

	always_comb begin
		st_d            = st_q;
		msg_stall       = 1'b1;
		blk_req.go      = 1'b0;
		blk_req.counter = ctr_eff;
		res_load        = 1'b0;
		res_next        = '0;
		case (st_q)
			cc20_pkg::TOP_IDLE: begin
				msg_stall = !out_free;
				if (msg_valid && out_free) begin
					if (off_eff == 6'd0) begin
						// block boundary: launch a fresh block, park the byte
						blk_req.go = 1'b1;
						st_d       = cc20_pkg::TOP_GEN;
					end else begin
						res_load          = 1'b1;
						res_next.out_byte = msg_data.data_byte ^ ks_byte;
						res_next.out_last = msg_data.last_byte;
					end
				end
			end
			cc20_pkg::TOP_GEN: begin
				if (blk_rsp.done) begin
					if (out_free) begin
						res_load = 1'b1;
						st_d     = cc20_pkg::TOP_IDLE;
					end else begin
						st_d = cc20_pkg::TOP_EMIT;
					end
				end
				res_next.out_byte = pend_q.data_byte ^ ks[0][7:0];
				res_next.out_last = pend_q.last_byte;
			end
			cc20_pkg::TOP_EMIT: begin
				if (out_free) begin
					res_load = 1'b1;
					st_d     = cc20_pkg::TOP_IDLE;
				end
				res_next.out_byte = pend_q.data_byte ^ ks[0][7:0];
				res_next.out_last = pend_q.last_byte;
			end
			default: begin
				st_d = cc20_pkg::TOP_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= cc20_pkg::TOP_IDLE;
			ctr_q       <= '0;
			off_q       <= '0;
			in_msg_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (msg_xfer) begin
				// last byte ends the message; next transfer reloads the counter
				in_msg_q <= !msg_data.last_byte;
				off_q    <= msg_data.last_byte ? 6'd0 : off_next;
				ctr_q    <= (off_next == 6'd0) ? ctr_eff + 32'd1 : ctr_eff;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg_xfer) pend_q <= msg_data;
		if (res_load) res_q <= res_next;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef SYNTHESIS
	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		blk_req.go |-> !blk_rsp.busy)
		else $error("block launched while busy");
	a_fast_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_xfer && off_eff != 6'd0) |=> res_valid)
		else $error("mid-block byte gave no result next cycle");
	a_done_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		blk_rsp.done |-> st_q == cc20_pkg::TOP_GEN)
		else $error("block done outside generate state");
`endif

endmodule
